>>> design/b58d_pkg.sv
// shared constants, types and the alphabet lookup of the base58 decoder
`timescale 1ns / 1ps

package b58d_pkg;

    localparam int ACC_WORDS  = 7;
    localparam int ACC_BITS   = 32 * ACC_WORDS;
    localparam int OUT_BYTES  = 1 + 4 * (ACC_WORDS - 1);
    localparam int FRAME_BITS = 8 * OUT_BYTES;
    localparam int CNT_W      = $clog2(OUT_BYTES);
    localparam int DIGIT_W    = 6;

    // the low byte of the top word plus all lower words are exactly the low bits
    typedef struct packed {
        logic [FRAME_BITS-1:0] data;
        logic                  bad;
    } frame_t;

    typedef struct packed {
        logic               bad;
        logic [DIGIT_W-1:0] value;
    } digit_t;

    // bitcoin alphabet, no 0 O I l; anything else is flagged and counts as zero
    function automatic digit_t digit_of(input logic [7:0] ch);
        digit_t     d;
        logic [7:0] v;
        d.bad = 1'b0;
        v     = 8'd0;
        if (ch >= 8'h31 && ch <= 8'h39)
        begin
            v = ch - 8'h31;
        end
        else if (ch >= 8'h41 && ch <= 8'h48)
        begin
            v = ch - 8'h41 + 8'd9;
        end
        else if (ch >= 8'h4a && ch <= 8'h4e)
        begin
            v = ch - 8'h4a + 8'd17;
        end
        else if (ch >= 8'h50 && ch <= 8'h5a)
        begin
            v = ch - 8'h50 + 8'd22;
        end
        else if (ch >= 8'h61 && ch <= 8'h6b)
        begin
            v = ch - 8'h61 + 8'd33;
        end
        else if (ch >= 8'h6d && ch <= 8'h7a)
        begin
            v = ch - 8'h6d + 8'd44;
        end
        else
        begin
            d.bad = 1'b1;
        end
        d.value = v[DIGIT_W-1:0];
        return d;
    endfunction

endpackage

>>> design/b58d_in_if.sv
// character stream interface of the base58 decoder
`timescale 1ns / 1ps

interface b58d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> design/b58d_out_if.sv
// byte stream interface of the base58 decoder
`timescale 1ns / 1ps

interface b58d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    logic       bad_char;

    modport source (output valid, output out_byte, output last_byte, output bad_char,
                    input ready);
    modport sink   (input valid, input out_byte, input last_byte, input bad_char,
                    output ready);
endinterface

>>> design/base58_decoder_25_bytes_core.sv
// top level of the base58 decoder: accumulator and byte serializer
`timescale 1ns / 1ps

// Decodes a bitcoin-alphabet base58 string, one character word per cycle while
// no last character is held, into a 25-byte result, most significant byte
// first, with bad_char set on every byte when any character of the string was
// outside the alphabet (such a character counts as digit zero). Characters
// enter at one per cycle while no last character is held: the accumulator
// multiplies its 224 bits by 58 with a shift-add in the cycle after the word is
// taken, and values past 224 bits wrap. The last character passes through the
// input register and, when the serializer is free, loads the frame register, and
// the 25 bytes leave from the frame register at one per cycle when the sink is
// ready. The next string's characters keep flowing in during a burst; only its
// last character is held until the previous burst has been fully taken. No
// clearing pass is needed after reset.

module base58_decoder_25_bytes_core (
    input  logic       clk,
    input  logic       rst_n,
    b58d_in_if.sink    chars,
    b58d_out_if.source bytes
);

    logic             frame_free;
    logic             frame_load;
    b58d_pkg::frame_t frame;

    b58d_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .frame_free (frame_free),
        .frame_load (frame_load),
        .frame      (frame)
    );

    b58d_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_load (frame_load),
        .frame      (frame),
        .frame_free (frame_free),
        .bytes      (bytes)
    );

endmodule

>>> design/b58d_accum.sv
// input register, digit decode and multiply-by-58 accumulator
`timescale 1ns / 1ps

module b58d_accum (
    input  logic             clk,
    input  logic             rst_n,
    b58d_in_if.sink          chars,
    input  logic             frame_free,
    output logic             frame_load,
    output b58d_pkg::frame_t frame
);

    logic                            s1_valid_reg;
    logic [b58d_pkg::DIGIT_W-1:0]    s1_digit_reg;
    logic                            s1_bad_reg;
    logic                            s1_last_reg;
    logic [b58d_pkg::ACC_BITS-1:0]   acc_reg;
    logic [b58d_pkg::ACC_BITS-1:0]   acc_next;
    logic                            err_reg;
    logic                            s1_advance;
    logic                            in_take;
    b58d_pkg::digit_t                dec;

    assign dec        = b58d_pkg::digit_of(chars.char_code);
    // a last character waits until the serializer can take the frame
    assign s1_advance = s1_valid_reg && (!s1_last_reg || frame_free);
    assign chars.ready = !s1_valid_reg || s1_advance;
    assign in_take    = chars.valid && chars.ready;

    // 58 = 64 - 8 + 2, carries out of the top word drop off
    assign acc_next = (acc_reg << 6) - (acc_reg << 3) + (acc_reg << 1)
                    + {{(b58d_pkg::ACC_BITS - b58d_pkg::DIGIT_W){1'b0}}, s1_digit_reg};

    assign frame_load = s1_advance && s1_last_reg;
    assign frame.data = acc_next[b58d_pkg::FRAME_BITS-1:0];
    assign frame.bad  = err_reg | s1_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_digit_reg <= dec.bad ? '0 : dec.value;
            s1_bad_reg   <= dec.bad;
            s1_last_reg  <= chars.last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                acc_reg <= '0;
                err_reg <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_next;
                err_reg <= err_reg | s1_bad_reg;
            end
        end
    end

endmodule

>>> design/b58d_serializer.sv
// frame register that hands out the decoded bytes one word at a time
`timescale 1ns / 1ps

module b58d_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_load,
    input  b58d_pkg::frame_t frame,
    output logic             frame_free,
    b58d_out_if.source       bytes
);

    logic [b58d_pkg::FRAME_BITS-1:0] frame_reg;
    logic                            bad_reg;
    logic                            busy_reg;
    logic [b58d_pkg::CNT_W-1:0]      cnt_reg;
    logic                            at_last;
    logic                            take;

    assign at_last    = cnt_reg == b58d_pkg::CNT_W'(b58d_pkg::OUT_BYTES - 1);
    assign take       = bytes.valid && bytes.ready;
    assign frame_free = !busy_reg || (take && at_last);

    assign bytes.valid     = busy_reg;
    assign bytes.out_byte  = frame_reg[b58d_pkg::FRAME_BITS-1 -: 8];
    assign bytes.last_byte = at_last;
    assign bytes.bad_char  = bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (frame_load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (take)
        begin
            if (at_last)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + b58d_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_load)
        begin
            frame_reg <= frame.data;
            bad_reg   <= frame.bad;
        end
        else if (take)
        begin
            frame_reg <= frame_reg << 8;
        end
    end

endmodule

>>> design/b58d_checker.sv
// port-level assertions of the base58 decoder and their bind
`timescale 1ns / 1ps

module b58d_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_byte,
    input logic       bad_char
);

    logic [b58d_pkg::CNT_W-1:0] seen_reg;

    // bytes taken since the previous end of burst
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            seen_reg <= last_byte ? '0 : seen_reg + b58d_pkg::CNT_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(last_byte) && $stable(bad_char))
        else $error("stalled output word changed");

    a_burst_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last_byte == (seen_reg == b58d_pkg::CNT_W'(b58d_pkg::OUT_BYTES - 1)))
        else $error("end of burst not on the 25th word");

    a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_byte |=> out_valid && bad_char == $past(bad_char))
        else $error("burst broke off or error flag changed inside a burst");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is idle");

    a_no_out_without_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(out_valid))
        else $error("burst started without a preceding input word");

endmodule

bind base58_decoder_25_bytes_core b58d_checker u_b58d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .out_valid (bytes.valid),
    .out_ready (bytes.ready),
    .out_byte  (bytes.out_byte),
    .last_byte (bytes.last_byte),
    .bad_char  (bytes.bad_char)
);

>>> verif/b58d_string_checker.sv
// checker of the base58 decoder: predicts every result byte and compares
`timescale 1ns / 1ps

module b58d_string_checker (
    input  logic clk,
    input  logic rst_n,
    b58d_in_if   chars,
    b58d_out_if  bytes,
    output int   mismatches,
    output int   pending,
    output int   bytes_checked
);

    typedef struct {
        logic [7:0] value;
        logic       lst;
        logic       bad;
    } byte_exp_t;

    string            alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    byte_exp_t        expected_bytes[$];
    logic [b58d_pkg::ACC_BITS-1:0] number;
    logic             flagged;
    int               burst_pos;

    // position in the alphabet, or -1 for a character outside it
    function automatic int base58_value(input logic [7:0] ch);
        for (int i = 0; i < 58; i++)
        begin
            if (alphabet[i] == ch)
                return i;
        end
        return -1;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%t mismatch on byte %0d of burst: %s expected %0h got %0h",
                 $realtime, burst_pos, what, want, got);
        mismatches++;
    endtask

    task automatic absorb_char(input logic [7:0] ch, input logic lst);
        int        d;
        byte_exp_t e;
        d = base58_value(ch);
        if (d < 0)
        begin
            flagged = 1'b1;
            d = 0;
        end
        // carry past the top word simply falls off
        number = number * b58d_pkg::ACC_BITS'(58) + b58d_pkg::ACC_BITS'(d);
        if (lst)
        begin
            for (int k = 0; k < b58d_pkg::OUT_BYTES; k++)
            begin
                e.value = number[b58d_pkg::FRAME_BITS-1-8*k -: 8];
                e.lst   = (k == b58d_pkg::OUT_BYTES - 1);
                e.bad   = flagged;
                expected_bytes.push_back(e);
            end
            number  = '0;
            flagged = 1'b0;
        end
    endtask

    task automatic check_byte();
        byte_exp_t e;
        if (expected_bytes.size() == 0)
        begin
            report_mismatch("unexpected word, value", 0, bytes.out_byte);
        end
        else
        begin
            e = expected_bytes.pop_front();
            if (bytes.out_byte !== e.value)
                report_mismatch("out_byte", e.value, bytes.out_byte);
            if (bytes.last_byte !== e.lst)
                report_mismatch("last_byte", e.lst, bytes.last_byte);
            if (bytes.bad_char !== e.bad)
                report_mismatch("bad_char", e.bad, bytes.bad_char);
            burst_pos = e.lst ? 0 : burst_pos + 1;
        end
        bytes_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number        = '0;
            flagged       = 1'b0;
            burst_pos     = 0;
            mismatches    = 0;
            bytes_checked = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (chars.valid && chars.ready)
                absorb_char(chars.char_code, chars.last_char);
            if (bytes.valid && bytes.ready)
                check_byte();
        end
        pending = expected_bytes.size();
    end

endmodule

>>> verif/base58_decoder_25_bytes_core_tb.sv
// testbench top of the base58 decoder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module base58_decoder_25_bytes_core_tb;

    logic clk;
    logic rst_n;

    b58d_in_if  chars_if ();
    b58d_out_if bytes_if ();

    int mismatches;
    int pending;
    int bytes_checked;

    string      alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    logic [7:0] text_buf[$];
    bit         calm;
    int         strings_sent;
    int         chars_sent;
    int         longest;
    int         drain_cycles;

    base58_decoder_25_bytes_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .bytes (bytes_if)
    );

    b58d_string_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .chars         (chars_if),
        .bytes         (bytes_if),
        .mismatches    (mismatches),
        .pending       (pending),
        .bytes_checked (bytes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2500000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // sink side stalls
    initial
    begin
        int run;
        int gap;
        bytes_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 8);
            gap = pick_gap();
            bytes_if.ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (gap > 0)
            begin
                bytes_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // valid stays high from one word to the next when there is no gap
    task automatic send_char(input logic [7:0] ch, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= ch;
        chars_if.last_char <= lst;
        do
            @(posedge clk);
        while (!chars_if.ready);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
        strings_sent++;
        if (text_buf.size() > longest)
            longest = text_buf.size();
    endtask

    task automatic hold_until_drained();
        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic make_random_text();
        int  len;
        int  r;
        bit  noisy;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(1, 12);
        else if (r < 90)
            len = $urandom_range(13, 34);
        else
            len = $urandom_range(35, 45);
        noisy = ($urandom_range(0, 99) < 20);
        text_buf.delete();
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 4) == 0)
                text_buf.push_back(8'($urandom_range(0, 255)));
            else
                text_buf.push_back(alphabet[$urandom_range(0, 57)]);
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        calm               = 1'b0;
        strings_sent       = 0;
        chars_sent         = 0;
        longest            = 0;
        chars_if.valid     <= 1'b0;
        chars_if.char_code <= 8'h00;
        chars_if.last_char <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest and largest digit, non-alphabet codes at both ends of the byte range
        text_buf = '{"1"};
        send_text();
        text_buf = '{"z"};
        send_text();
        text_buf = '{8'h00};
        send_text();
        text_buf = '{8'hff};
        send_text();
        // excluded look-alikes and neighbors of the ranges, then a good last word
        text_buf = '{"0", "O", "I", "l", ":", "{", "2"};
        send_text();
        // every range edge of the alphabet
        text_buf = '{"1", "9", "A", "H", "J", "N", "P", "Z", "a", "k", "m", "z"};
        send_text();
        hold_until_drained();

        while (chars_sent < 310)
        begin
            calm = ($urandom_range(0, 3) == 0);
            for (int s = 0; s < 4 && chars_sent < 310; s++)
            begin
                make_random_text();
                send_text();
            end
            if ($urandom_range(0, 4) == 0)
                hold_until_drained();
        end
        calm = 1'b0;
        chars_if.valid <= 1'b0;

        drain_cycles = 0;
        @(posedge clk);
        while (pending != 0 && drain_cycles < 20000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (40) @(posedge clk);

        $display("covered %0d strings, %0d characters, longest %0d characters",
                 strings_sent, chars_sent, longest);
        $display("checked %0d result bytes, %0d still outstanding", bytes_checked, pending);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
